/* rtl/vaq_pkg.sv */
// shared constants and conversion functions for the vertex attribute quantizer
`default_nettype none
package vaq_pkg;

  localparam logic [31:0] F32_ABS          = 32'h7FFF_FFFF;
  localparam logic [31:0] F32_INF          = 32'h7F80_0000;
  localparam logic [31:0] F32_HALF_MAX     = 32'h477F_E000;
  localparam logic [31:0] F32_HALF_OVF     = 32'h477F_F000;
  localparam logic [31:0] F32_HALF_MINNORM = 32'h3880_0000;
  localparam logic [31:0] F32_ONE          = 32'h3F80_0000;
  localparam logic [15:0] HALF_QNAN        = 16'h7E00;
  localparam logic [14:0] HALF_INF         = 15'h7C00;

  // binary32 to binary16, round to nearest even
  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic [30:0] mag;
    logic [15:0] sgn;
    logic [14:0] h;
    logic [12:0] rem;
    logic [23:0] m;
    logic [4:0]  s;
    logic [23:0] hs;
    logic [23:0] rs;
    logic [23:0] hf;
    logic [7:0]  e;
    mag = b[30:0];
    sgn = {b[31], 15'd0};
    e   = mag[30:23];
    to_half = sgn;
    if ({1'b0, mag} > F32_INF) begin
      to_half = HALF_QNAN;
    end else if ({1'b0, mag} >= F32_HALF_OVF) begin
      to_half = sgn | {1'b0, HALF_INF};
    end else if ({1'b0, mag} >= F32_HALF_MINNORM) begin
      h   = {5'(e - 8'd112), mag[22:13]};
      rem = mag[12:0];
      if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) h = h + 15'd1;
      to_half = sgn | {1'b0, h};
    end else if (e >= 8'd102) begin
      // half subnormal, shift 14..24
      m  = {1'b1, mag[22:0]};
      s  = 5'(8'd126 - e);
      hs = m >> s;
      rs = m & ((24'd1 << s) - 24'd1);
      hf = 24'd1 << (s - 5'd1);
      if (rs > hf || (rs == hf && hs[0])) hs = hs + 24'd1;
      to_half = sgn | {1'b0, hs[14:0]};
    end
  endfunction

  // binary32 to unorm16, exact floor(t*65535 + 1/2)
  function automatic logic [15:0] to_unorm16(input logic [31:0] b);
    logic [30:0] mag;
    logic [23:0] m;
    logic [7:0]  s;
    logic [39:0] prod;
    logic [40:0] sum;
    logic [40:0] sh;
    mag = b[30:0];
    to_unorm16 = 16'd0;
    if ({1'b0, mag} > F32_INF) begin
      to_unorm16 = 16'hFFFF;
    end else if (b[31]) begin
      to_unorm16 = 16'd0;
    end else if ({1'b0, mag} >= F32_ONE) begin
      to_unorm16 = 16'hFFFF;
    end else begin
      if (mag[30:23] == 8'd0) begin
        m = {1'b0, mag[22:0]};
        s = 8'd149;
      end else begin
        m = {1'b1, mag[22:0]};
        s = 8'd150 - mag[30:23];
      end
      if (s <= 8'd40) begin
        prod = {m, 16'd0} - {16'd0, m};
        sum  = {1'b0, prod} + (41'd1 << (s - 8'd1));
        sh   = sum >> s;
        to_unorm16 = sh[15:0];
      end
    end
  endfunction

  // binary32 times 127 rounded to single, truncated, saturated
  function automatic logic [7:0] to_snorm8(input logic [31:0] b);
    logic [7:0]  e;
    logic [30:0] prod;
    logic [31:0] rnd;
    logic [5:0]  sh;
    logic [30:0] mag;
    logic [7:0]  iv;
    e = b[30:23];
    to_snorm8 = 8'd0;
    if (e == 8'hFF) begin
      if (b[22:0] == 23'd0) to_snorm8 = b[31] ? 8'h80 : 8'h7F;
    end else if (e >= 8'd134) begin
      // |f| >= 128 so |p| well beyond range
      to_snorm8 = b[31] ? 8'h80 : 8'h7F;
    end else if (e >= 8'd120) begin
      // product of 24-bit mantissa and 127, 31 bits
      prod = ({7'd0, 1'b1, b[22:0]} << 7) - {7'd0, 1'b1, b[22:0]};
      // round to 24 significant bits: prod lies in [2^29, 2^31)
      if (prod[30]) begin
        rnd = {1'b0, prod[30:7], 7'd0};
        if (prod[6] && (prod[5:0] != 6'd0 || prod[7])) rnd = rnd + 32'h80;
      end else begin
        rnd = {1'b0, prod[30:6], 6'd0};
        if (prod[5] && (prod[4:0] != 5'd0 || prod[6])) rnd = rnd + 32'h40;
      end
      // value = rnd * 2^(e-150); integer part = rnd >> (150-e)
      sh  = 6'(8'd150 - e);
      mag = rnd[30:0] >> sh;
      if (rnd[31] || mag >= 31'd128) begin
        to_snorm8 = b[31] ? 8'h80 : 8'h7F;
      end else begin
        iv = mag[7:0];
        if (b[31]) to_snorm8 = 8'(-iv);
        else if (iv >= 8'd127) to_snorm8 = 8'h7F;
        else to_snorm8 = iv;
      end
    end
  endfunction

  // position fits half range, nan counts as safe
  function automatic logic pos_safe(input logic [31:0] b);
    logic [31:0] mag;
    mag = b & F32_ABS;
    pos_safe = !(mag > F32_HALF_MAX && mag <= F32_INF);
  endfunction

endpackage
`default_nettype wire

/* rtl/vertex_attribute_quantizer.sv */
// vertex attribute quantizer top level
// an accepted start passes the input register, then the result register, to reach out_valid
// throughput: one word per cycle; busy is tied low since the receiver cannot stall
// the conversions are short combinational logic between the two register stages
// reset: synchronous active-low rst_n clears the valid pipeline only
// payload registers are not reset
`default_nettype none
module vertex_attribute_quantizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_tex_u,
  input  wire logic [31:0] in_tex_v,
  input  wire logic [31:0] in_normal_x,
  input  wire logic [31:0] in_normal_y,
  input  wire logic [31:0] in_normal_z,
  input  wire logic [31:0] in_color_rgba,
  input  wire logic        in_last_in_batch,
  output logic             out_valid,
  output logic [15:0]      out_half_x,
  output logic [15:0]      out_half_y,
  output logic [15:0]      out_half_z,
  output logic [15:0]      out_unorm_u,
  output logic [15:0]      out_unorm_v,
  output logic signed [7:0] out_snorm_x,
  output logic signed [7:0] out_snorm_y,
  output logic signed [7:0] out_snorm_z,
  output logic [31:0]      out_color_out,
  output logic             out_half_range_ok,
  output logic             out_last_out
);

  logic        vld_r;
  logic        ovld_r;
  logic [31:0] px_r, py_r, pz_r, tu_r, tv_r, nx_r, ny_r, nz_r, col_r;
  logic        last_r;

  assign busy = 1'b0;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= start;
      ovld_r <= vld_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (start) begin
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      pz_r   <= in_pos_z;
      tu_r   <= in_tex_u;
      tv_r   <= in_tex_v;
      nx_r   <= in_normal_x;
      ny_r   <= in_normal_y;
      nz_r   <= in_normal_z;
      col_r  <= in_color_rgba;
      last_r <= in_last_in_batch;
    end
  end

  // conversions into result register
  always_ff @(posedge clk) begin
    if (vld_r) begin
      out_half_x        <= vaq_pkg::to_half(px_r);
      out_half_y        <= vaq_pkg::to_half(py_r);
      out_half_z        <= vaq_pkg::to_half(pz_r);
      out_unorm_u       <= vaq_pkg::to_unorm16(tu_r);
      out_unorm_v       <= vaq_pkg::to_unorm16(tv_r);
      out_snorm_x       <= vaq_pkg::to_snorm8(nx_r);
      out_snorm_y       <= vaq_pkg::to_snorm8(ny_r);
      out_snorm_z       <= vaq_pkg::to_snorm8(nz_r);
      out_color_out     <= col_r;
      out_half_range_ok <= vaq_pkg::pos_safe(px_r) & vaq_pkg::pos_safe(py_r)
                           & vaq_pkg::pos_safe(pz_r);
      out_last_out      <= last_r;
    end
  end

  assign out_valid = ovld_r;

  // result strobe follows accepted start through the input register and the result register
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid) else $error("missing result");
  a_nolat: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> ##1 !out_valid) else $error("spurious result");
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> out_color_out == $past(col_r)) else $error("color mismatch");

endmodule
`default_nettype wire
